// ===== sv/rpss_pkg.sv =====
`timescale 1ns / 1ps

package rpss_pkg;

    localparam int NUM_TASKS  = 7;
    localparam int NUM_SEMS   = 16;
    localparam int TICK_WIDTH = 16;

    // fixed field widths of the command and result transfers
    localparam int TASK_W = 3;
    localparam int SEM_W  = 4;
    localparam int OP_W   = 3;

    localparam int SEM_AW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

    localparam int IN_DATA_W  = TASK_W + SEM_W + 1 + TICK_WIDTH;
    localparam int IN_BYTES_W = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_BITS   = TASK_W + (NUM_TASKS + 1) + 2;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_SUSPEND = 3'd1,
        OP_RESUME  = 3'd2,
        OP_DELAY   = 3'd3,
        OP_CREATE  = 3'd4,
        OP_PEND    = 3'd5,
        OP_POST    = 3'd6,
        OP_CLEAN   = 3'd7
    } opcode_t;

    // command broadcast along the row of task cells
    typedef struct packed {
        opcode_t               op;
        logic [TASK_W-1:0]     tid;
        logic [SEM_W-1:0]      sem;
        logic [TICK_WIDTH-1:0] ticks;
        logic [TASK_W-1:0]     cur;
        logic                  sem_ok;
        logic                  sem_avail;
        logic                  sem_shared;
    } cell_cmd_t;

    typedef struct packed {
        logic ready;
        logic tmo;
        logic chosen;
    } cell_stat_t;

endpackage

// ===== sv/rpss_task_cell.sv =====
`timescale 1ns / 1ps

module rpss_task_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rpss_pkg::TASK_W-1:0]   cell_id,
    input  logic                          apply,
    input  rpss_pkg::cell_cmd_t           cmd,
    input  logic                          claim_in,
    output logic                          claim_out,
    input  logic                          sel_in,
    output logic                          sel_out,
    output rpss_pkg::cell_stat_t          stat
);

    logic                            ready_reg, ready_next;
    logic [rpss_pkg::TICK_WIDTH-1:0] wcnt_reg, wcnt_next;
    logic                            pend_reg, pend_next;
    logic [rpss_pkg::SEM_W-1:0]      psem_reg, psem_next;
    logic                            listed_reg, listed_next;
    logic                            tmo_reg, tmo_next;
    logic                            waiter;
    logic                            is_tid;
    logic                            is_cur;

    assign waiter = pend_reg & listed_reg & (psem_reg == cmd.sem);
    assign is_tid = (cmd.tid == cell_id);
    assign is_cur = (cmd.cur == cell_id);

    assign claim_out   = claim_in | waiter;
    assign sel_out     = sel_in | ready_reg;
    assign stat.ready  = ready_reg;
    assign stat.tmo    = tmo_reg;
    assign stat.chosen = ready_reg & ~sel_in;

    always_comb begin
        ready_next  = ready_reg;
        wcnt_next   = wcnt_reg;
        pend_next   = pend_reg;
        psem_next   = psem_reg;
        listed_next = listed_reg;
        tmo_next    = tmo_reg;
        if (apply) begin
            unique case (cmd.op)
                rpss_pkg::OP_TICK: begin
                    if (wcnt_reg != '0 && wcnt_reg != '1) begin
                        wcnt_next = wcnt_reg - 1'b1;
                        if (wcnt_reg == rpss_pkg::TICK_WIDTH'(1)) begin
                            ready_next = 1'b1;
                            if (pend_reg) begin
                                pend_next   = 1'b0;
                                listed_next = 1'b0;
                                tmo_next    = 1'b1;
                            end
                        end
                    end
                end
                rpss_pkg::OP_SUSPEND: begin
                    if (is_tid) begin
                        wcnt_next  = '0;
                        ready_next = 1'b0;
                    end
                end
                rpss_pkg::OP_RESUME: begin
                    if (is_tid) begin
                        ready_next = 1'b1;
                        wcnt_next  = '0;
                        if (pend_reg) begin
                            pend_next   = 1'b0;
                            listed_next = 1'b0;
                            tmo_next    = 1'b1;
                        end
                    end
                end
                rpss_pkg::OP_DELAY: begin
                    if (is_cur && cmd.ticks != '0) begin
                        ready_next = 1'b0;
                        wcnt_next  = cmd.ticks;
                    end
                end
                rpss_pkg::OP_CREATE: begin
                    // waiters are dropped from the list but stay blocked
                    if (cmd.sem_ok && waiter) begin
                        listed_next = 1'b0;
                    end
                end
                rpss_pkg::OP_PEND: begin
                    if (cmd.sem_ok && is_cur) begin
                        if (cmd.sem_avail) begin
                            tmo_next = 1'b0;
                        end else begin
                            listed_next = 1'b1;
                            pend_next   = 1'b1;
                            psem_next   = cmd.sem;
                            wcnt_next   = cmd.ticks;
                            tmo_next    = 1'b0;
                            ready_next  = 1'b0;
                        end
                    end
                end
                rpss_pkg::OP_POST: begin
                    // exclusive post only wakes the first waiter along the row
                    if (cmd.sem_ok && waiter && (cmd.sem_shared || !claim_in)) begin
                        ready_next  = 1'b1;
                        wcnt_next   = '0;
                        pend_next   = 1'b0;
                        listed_next = 1'b0;
                        tmo_next    = 1'b0;
                    end
                end
                rpss_pkg::OP_CLEAN: begin
                    ready_next = ready_reg;
                end
                default: begin
                    ready_next = ready_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg  <= 1'b0;
            wcnt_reg   <= '0;
            pend_reg   <= 1'b0;
            listed_reg <= 1'b0;
            tmo_reg    <= 1'b0;
        end else begin
            ready_reg  <= ready_next;
            wcnt_reg   <= wcnt_next;
            pend_reg   <= pend_next;
            listed_reg <= listed_next;
            tmo_reg    <= tmo_next;
        end
    end

    always_ff @(posedge aclk) begin
        psem_reg <= psem_next;
    end

endmodule

// ===== sv/rtos_priority_scheduler_semaphores_unit.sv =====
`timescale 1ns / 1ps

// channel   | direction | handshake          | contents
// ----------+-----------+--------------------+--------------------------------------------
// command   | in        | s_tvalid / s_tready| tuser: opcode; tdata: task, sem, kind, ticks
// result    | out       | m_tvalid / m_tready| tdata: running task, ready bits, granted,
//           |           |                    |        running task timed out
//
// each command passes the transfer in the idle state, the execute state in which the row of task
// cells and the semaphore bits update, and the schedule state in which the ready chain through
// the cells picks the running task and the result register is loaded
// reset (aresetn low, synchronous) leaves only the idle task ready, idle running
// a result waiting in the output register does not block the next command transfer;
// only loading a new result waits until the previous one has been taken

module rtos_priority_scheduler_semaphores_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: task_id, sem_index, sem_kind, tick_count
    input  logic [rpss_pkg::IN_BYTES_W-1:0]   s_tdata,
    // tuser: opcode
    input  logic [rpss_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: running_task, ready_bits, granted, run_timed_out, zero padding
    output logic [rpss_pkg::OUT_DATA_W-1:0]   m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_SCHED = 3'b100
    } state_t;

    localparam int NT = rpss_pkg::NUM_TASKS;
    localparam int TW = rpss_pkg::TASK_W;
    localparam int SW = rpss_pkg::SEM_W;

    state_t state_reg, state_next;

    // latched command
    rpss_pkg::opcode_t               op_reg;
    logic [TW-1:0]                   tid_reg;
    logic [SW-1:0]                   sem_reg;
    logic                            kind_reg;
    logic [rpss_pkg::TICK_WIDTH-1:0] ticks_reg;

    logic [TW-1:0]                   cur_reg, cur_next;
    logic                            granted_reg, granted_next;
    logic [rpss_pkg::NUM_SEMS-1:0]   shared_reg, shared_next;
    logic [rpss_pkg::NUM_SEMS-1:0]   avail_reg, avail_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [rpss_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic                            in_xfer;
    logic                            out_load;
    logic                            sem_ok;
    logic [rpss_pkg::SEM_AW-1:0]     sem_sel;
    logic                            sem_avail;
    logic                            sem_shared;
    rpss_pkg::cell_cmd_t             cmd;
    rpss_pkg::cell_stat_t            stat [NT];
    logic [NT:0]                     claim;
    logic [NT:0]                     sel;
    logic [NT-1:0]                   ready_vec;
    logic [TW-1:0]                   pick;
    logic                            pick_tmo;
    logic [NT:0]                     ready_bits;
    logic [rpss_pkg::OUT_DATA_W-1:0] out_word;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    // semaphore lookup for the latched command
    assign sem_ok     = ({1'b0, sem_reg} < (SW + 1)'(rpss_pkg::NUM_SEMS));
    assign sem_sel    = sem_reg[rpss_pkg::SEM_AW-1:0];
    assign sem_avail  = sem_ok & avail_reg[sem_sel];
    assign sem_shared = sem_ok & shared_reg[sem_sel];

    always_comb begin
        cmd.op         = op_reg;
        cmd.tid        = tid_reg;
        cmd.sem        = sem_reg;
        cmd.ticks      = ticks_reg;
        cmd.cur        = cur_reg;
        cmd.sem_ok     = sem_ok;
        cmd.sem_avail  = sem_avail;
        cmd.sem_shared = sem_shared;
    end

    // row of task cells: the claim chain finds the first waiter, the select chain
    // finds the lowest ready task
    assign claim[0] = 1'b0;
    assign sel[0]   = 1'b0;

    for (genvar i = 0; i < NT; i++) begin : g_cell
        rpss_task_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_id   (TW'(i)),
            .apply     (state_reg == ST_EXEC),
            .cmd       (cmd),
            .claim_in  (claim[i]),
            .claim_out (claim[i+1]),
            .sel_in    (sel[i]),
            .sel_out   (sel[i+1]),
            .stat      (stat[i])
        );
        assign ready_vec[i] = stat[i].ready;
    end

    // encode the chosen cell; idle runs when no cell is chosen
    always_comb begin
        pick     = TW'(NT);
        pick_tmo = 1'b0;
        for (int i = 0; i < NT; i++) begin
            if (stat[i].chosen) begin
                pick     = TW'(i);
                pick_tmo = stat[i].tmo;
            end
        end
    end

    assign ready_bits = {1'b1, ready_vec};
    assign out_word   = {(rpss_pkg::OUT_DATA_W - rpss_pkg::OUT_BITS)'(0),
                         pick_tmo, granted_reg, ready_bits, pick};
    assign out_load   = (state_reg == ST_SCHED) && (!m_tvalid_reg || m_tready);

    // semaphore bits and grant
    always_comb begin
        shared_next  = shared_reg;
        avail_next   = avail_reg;
        granted_next = granted_reg;
        if (state_reg == ST_EXEC) begin
            granted_next = 1'b0;
            if (sem_ok) begin
                unique case (op_reg)
                    rpss_pkg::OP_CREATE: begin
                        shared_next[sem_sel] = kind_reg;
                        avail_next[sem_sel]  = 1'b0;
                    end
                    rpss_pkg::OP_PEND: begin
                        if (sem_avail) begin
                            granted_next = 1'b1;
                            if (!sem_shared) begin
                                avail_next[sem_sel] = 1'b0;
                            end
                        end
                    end
                    rpss_pkg::OP_POST: begin
                        // exclusive post with nobody waiting leaves it available
                        if (sem_shared || !claim[NT]) begin
                            avail_next[sem_sel] = 1'b1;
                        end
                    end
                    rpss_pkg::OP_CLEAN: begin
                        avail_next[sem_sel] = 1'b0;
                    end
                    default: begin
                        avail_next = avail_reg;
                    end
                endcase
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_SCHED;
            end
            ST_SCHED: begin
                if (out_load) begin
                    cur_next      = pick;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_reg      <= TW'(NT);
            granted_reg  <= 1'b0;
            shared_reg   <= '0;
            avail_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            granted_reg  <= granted_next;
            shared_reg   <= shared_next;
            avail_reg    <= avail_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // command and result payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            op_reg    <= rpss_pkg::opcode_t'(s_tuser);
            tid_reg   <= s_tdata[TW-1:0];
            sem_reg   <= s_tdata[TW+SW-1:TW];
            kind_reg  <= s_tdata[TW+SW];
            ticks_reg <= s_tdata[TW+SW+rpss_pkg::TICK_WIDTH:TW+SW+1];
        end
        if (out_load) begin
            out_data_reg <= out_word;
        end
    end

endmodule
